// ----- rtl/tilemap_pixel_generator_assert.svh -----
// Assertion macros shared by the tile-map pixel generator modules.
`ifndef TILEMAP_PIXEL_GENERATOR_ASSERT_SVH
`define TILEMAP_PIXEL_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define TPG_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tile-map pixel generator check failed");
`define TPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tile-map pixel generator check failed");
`else
`define TPG_ASSERT_HOLDS(lbl, ante, cons)
`define TPG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/tpg_pkg.sv -----
// Shared types, constants and palette function of the tile-map pixel generator.
package tpg_pkg;

  typedef enum logic [2:0] {
    CMD_TILE    = 3'd0,
    CMD_COLOR   = 3'd1,
    CMD_PATTERN = 3'd2,
    CMD_BALL    = 3'd3,
    CMD_RENDER  = 3'd4
  } cmd_t;

  localparam int TILE_AW = 10;
  localparam int PAT_AW  = 11;
  localparam int TILE_DEPTH = 1 << TILE_AW;
  localparam int PAT_DEPTH  = 1 << PAT_AW;

  // Tile rows are scanned two rows ahead of the screen row.
  localparam logic [4:0] TILE_ROW_OFFSET = 5'd2;

  // Ball window edges, already shifted by the eight-pixel column offset.
  localparam logic signed [9:0] BALL_ROW_BASE = 10'sd240;
  localparam logic signed [9:0] BALL_COL_BASE = 10'sd256;
  localparam logic signed [9:0] BALL_FIRST    = 10'sd1;
  localparam logic signed [9:0] BALL_SIZE     = 10'sd4;
  localparam logic [15:0]       BALL_COLOR    = 16'hFFFF;

  // Resistor-weighted DAC levels, rounded.
  localparam logic [7:0] LVL_RG [0:7] = '{8'd0, 8'd36, 8'd71, 8'd107,
                                          8'd148, 8'd184, 8'd219, 8'd255};
  localparam logic [7:0] LVL_B  [0:3] = '{8'd0, 8'd82, 8'd173, 8'd255};

  typedef struct packed {
    logic [2:0]  cmd;
    logic [10:0] addr;
    logic [7:0]  data;
    logic [7:0]  ball_h;
    logic [7:0]  ball_v;
    logic        ball_en;
    logic [7:0]  x;
    logic [7:0]  y;
  } item_t;

  // Attribute byte to byte-swapped RGB565.
  function automatic logic [15:0] palette(input logic [7:0] attr);
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [15:0] c;
    r = LVL_RG[attr[2:0]];
    g = LVL_RG[attr[5:3]];
    b = LVL_B[attr[7:6]];
    c = {r[7:3], g[7:2], b[7:3]};
    return {c[7:0], c[15:8]};
  endfunction

endpackage

// ----- rtl/tpg_tile_fetch.sv -----
// First stage: tile-code and colour-attribute stores, their clearing pass and reads.
`include "tilemap_pixel_generator_assert.svh"
module tpg_tile_fetch (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tpg_pkg::item_t      in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tpg_pkg::item_t      out_item,
  output logic [7:0]          tile_code,
  output logic [7:0]          attr
);

  logic [7:0] tile_mem  [tpg_pkg::TILE_DEPTH];
  logic [7:0] color_mem [tpg_pkg::TILE_DEPTH];

  logic                       clr_busy;
  logic [tpg_pkg::TILE_AW-1:0] clr_addr;
  logic                       load;
  logic [4:0]                 tile_row;
  logic [tpg_pkg::TILE_AW-1:0] off;

  assign in_stall = clr_busy || (out_valid && out_stall);
  assign load     = in_valid && !in_stall;
  assign tile_row = in_item.y[7:3] + tpg_pkg::TILE_ROW_OFFSET;
  assign off      = {tile_row, in_item.x[7:3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy  <= 1'b1;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == '1) begin
          clr_busy <= 1'b0;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      tile_mem[clr_addr]  <= '0;
      color_mem[clr_addr] <= '0;
    end else if (load && in_item.cmd == tpg_pkg::CMD_TILE) begin
      tile_mem[in_item.addr[tpg_pkg::TILE_AW-1:0]] <= in_item.data;
    end else if (load && in_item.cmd == tpg_pkg::CMD_COLOR) begin
      color_mem[in_item.addr[tpg_pkg::TILE_AW-1:0]] <= in_item.data;
    end
    if (load) begin
      tile_code <= tile_mem[off];
      attr      <= color_mem[off];
      out_item  <= in_item;
    end
  end

  `TPG_ASSERT_HOLDS(a_clear_full_sweep, $fell(clr_busy), $past(clr_addr) == '1)
  `TPG_ASSERT_NEXT(a_stalled_beat_held, out_valid && out_stall, out_valid && $stable(out_item))

endmodule

// ----- rtl/tpg_pattern_fetch.sv -----
// Second stage: character pattern store and palette lookup.
module tpg_pattern_fetch (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tpg_pkg::item_t      in_item,
  input  logic [7:0]          tile_code,
  input  logic [7:0]          attr,
  output logic                out_valid,
  input  logic                out_stall,
  output tpg_pkg::item_t      out_item,
  output logic [7:0]          pat_bits,
  output logic [15:0]         color
);

  logic [7:0] pat_mem [tpg_pkg::PAT_DEPTH];

  logic                       load;
  logic [tpg_pkg::PAT_AW-1:0] pat_addr;

  assign in_stall = out_valid && out_stall;
  assign load     = in_valid && !in_stall;
  assign pat_addr = {tile_code, in_item.y[2:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Pattern writes are done here, in stream order with the pattern reads.
  always_ff @(posedge clk) begin
    if (load && in_item.cmd == tpg_pkg::CMD_PATTERN) begin
      pat_mem[in_item.addr] <= in_item.data;
    end
    if (load) begin
      pat_bits <= pat_mem[pat_addr];
      color    <= tpg_pkg::palette(attr);
      out_item <= in_item;
    end
  end

endmodule

// ----- rtl/tpg_compose.sv -----
// Third stage: ball registers, ball overlay and the output register.
`include "tilemap_pixel_generator_assert.svh"
module tpg_compose (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tpg_pkg::item_t      in_item,
  input  logic [7:0]          pat_bits,
  input  logic [15:0]         color,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         pixel_color,
  output logic                pixel_drawn
);

  logic [7:0] ball_h;
  logic [7:0] ball_v;
  logic       ball_on;

  logic              load;
  logic              is_render;
  logic              pat_hit;
  logic              ball_hit;
  logic signed [9:0] dy;
  logic signed [9:0] dx;

  assign in_stall  = out_valid && out_stall;
  assign load      = in_valid && !in_stall;
  assign is_render = in_item.cmd == tpg_pkg::CMD_RENDER;
  assign pat_hit   = pat_bits[~in_item.x[2:0]];

  assign dy = tpg_pkg::BALL_ROW_BASE - $signed({2'b00, ball_v})
              - $signed({2'b00, in_item.y});
  assign dx = tpg_pkg::BALL_COL_BASE - $signed({2'b00, ball_h})
              - $signed({2'b00, in_item.x});
  assign ball_hit = ball_on && dy >= tpg_pkg::BALL_FIRST && dy <= tpg_pkg::BALL_SIZE
                    && dx >= tpg_pkg::BALL_FIRST && dx <= tpg_pkg::BALL_SIZE;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ball_h    <= '0;
      ball_v    <= '0;
      ball_on   <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= is_render;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load && in_item.cmd == tpg_pkg::CMD_BALL) begin
        ball_h  <= in_item.ball_h;
        ball_v  <= in_item.ball_v;
        ball_on <= in_item.ball_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && is_render) begin
      pixel_drawn <= ball_hit || pat_hit;
      if (ball_hit) begin
        pixel_color <= tpg_pkg::BALL_COLOR;
      end else if (pat_hit) begin
        pixel_color <= color;
      end else begin
        pixel_color <= '0;
      end
    end
  end

  `TPG_ASSERT_HOLDS(a_background_black, out_valid && !pixel_drawn, pixel_color == '0)

endmodule

// ----- rtl/tilemap_pixel_generator.sv -----
// Top level of the tile-map pixel generator: three-stage pipeline.
// Throughput: one beat per cycle unless stalled; the stages are the
// tile/colour store read, the pattern store read with palette lookup, and the
// ball overlay register. Reset: synchronous; afterwards a clearing pass over
// all 1024 addresses zeroes the tile-code and colour stores, during which
// in_stall stays high.
module tilemap_pixel_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [10:0] addr,
  input  logic [7:0]  data,
  input  logic [7:0]  ball_h_in,
  input  logic [7:0]  ball_v_in,
  input  logic        ball_enable_in,
  input  logic [7:0]  pixel_x,
  input  logic [7:0]  pixel_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pixel_color,
  output logic        pixel_drawn
);

  tpg_pkg::item_t in_item;
  tpg_pkg::item_t s1_item;
  tpg_pkg::item_t s2_item;
  logic           s1_valid;
  logic           s1_stall;
  logic           s2_valid;
  logic           s2_stall;
  logic [7:0]     s1_tile_code;
  logic [7:0]     s1_attr;
  logic [7:0]     s2_pat_bits;
  logic [15:0]    s2_color;

  assign in_item = '{cmd: cmd, addr: addr, data: data, ball_h: ball_h_in,
                     ball_v: ball_v_in, ball_en: ball_enable_in,
                     x: pixel_x, y: pixel_y};

  tpg_tile_fetch u_tile_fetch (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (s1_valid),
    .out_stall (s1_stall),
    .out_item  (s1_item),
    .tile_code (s1_tile_code),
    .attr      (s1_attr)
  );

  tpg_pattern_fetch u_pattern_fetch (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_stall  (s1_stall),
    .in_item   (s1_item),
    .tile_code (s1_tile_code),
    .attr      (s1_attr),
    .out_valid (s2_valid),
    .out_stall (s2_stall),
    .out_item  (s2_item),
    .pat_bits  (s2_pat_bits),
    .color     (s2_color)
  );

  tpg_compose u_compose (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s2_valid),
    .in_stall    (s2_stall),
    .in_item     (s2_item),
    .pat_bits    (s2_pat_bits),
    .color       (s2_color),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_color (pixel_color),
    .pixel_drawn (pixel_drawn)
  );

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the tile-map pixel generator: scoreboard class and beat drivers.
`timescale 1ns / 1ps

module tb;

  localparam int QUIET_LIMIT = 5000;

  typedef struct {
    logic [15:0] color;
    logic        drawn;
  } pixel_t;

  class pixel_tracker;
    logic [7:0]  tile_codes [tpg_pkg::TILE_DEPTH];
    logic [7:0]  color_attrs [tpg_pkg::TILE_DEPTH];
    logic [7:0]  pattern_rom [tpg_pkg::PAT_DEPTH];
    bit          pat_written [tpg_pkg::PAT_DEPTH];
    logic [7:0]  ball_h;
    logic [7:0]  ball_v;
    logic        ball_on;
    pixel_t      pending_pixels [$];
    int          errors;

    function new();
      foreach (tile_codes[i]) begin
        tile_codes[i] = 8'h00;
        color_attrs[i] = 8'h00;
      end
      foreach (pattern_rom[i]) begin
        pattern_rom[i] = 8'h00;
        pat_written[i] = 1'b0;
      end
      ball_h = 8'h00;
      ball_v = 8'h00;
      ball_on = 1'b0;
      errors = 0;
    endfunction

    function logic [7:0] rg_level(logic [2:0] idx);
      case (idx)
        3'd0: return 8'd0;
        3'd1: return 8'd36;
        3'd2: return 8'd71;
        3'd3: return 8'd107;
        3'd4: return 8'd148;
        3'd5: return 8'd184;
        3'd6: return 8'd219;
        default: return 8'd255;
      endcase
    endfunction

    function logic [7:0] b_level(logic [1:0] idx);
      case (idx)
        2'd0: return 8'd0;
        2'd1: return 8'd82;
        2'd2: return 8'd173;
        default: return 8'd255;
      endcase
    endfunction

    function logic [15:0] attr_to_rgb(logic [7:0] attr);
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [15:0] word;
      r = rg_level(attr[2:0]);
      g = rg_level(attr[5:3]);
      b = b_level(attr[7:6]);
      word = {r[7:3], g[7:2], b[7:3]};
      return {word[7:0], word[15:8]};
    endfunction

    // Tile-store index of the cell holding screen pixel (x, y).
    function int cell_index(int x, int y);
      int rx;
      int tcol;
      int trow;
      int c;
      rx = x + 8;
      tcol = rx >> 3;
      trow = (y >> 3) + 2;
      c = (tcol - 1) & 'hFFFF;
      if (c & 'h20)
        return (trow + ((c & 1) << 5)) & 'h3FF;
      return (c + (trow << 5)) & 'h3FF;
    endfunction

    function int pattern_slot(int x, int y);
      return ((int'(tile_codes[cell_index(x, y)]) << 3) + (y & 7)) & 'h7FF;
    endfunction

    function pixel_t predict_pixel(int x, int y);
      pixel_t px;
      int     rx;
      int     off;
      int     bx;
      int     by;
      logic [7:0] bits;
      rx = x + 8;
      off = cell_index(x, y);
      bits = pattern_rom[pattern_slot(x, y)];
      px.color = 16'h0000;
      px.drawn = 1'b0;
      if (bits[7 - (rx & 7)]) begin
        px.color = attr_to_rgb(color_attrs[off]);
        px.drawn = 1'b1;
      end
      bx = 264 - int'(ball_h);
      by = 240 - int'(ball_v);
      if (ball_on && y >= by - 4 && y <= by - 1 && rx >= bx - 4 && rx <= bx - 1) begin
        px.color = 16'hFFFF;
        px.drawn = 1'b1;
      end
      return px;
    endfunction

    function void take_command(tpg_pkg::item_t b);
      case (b.cmd)
        tpg_pkg::CMD_TILE:    tile_codes[b.addr[9:0]] = b.data;
        tpg_pkg::CMD_COLOR:   color_attrs[b.addr[9:0]] = b.data;
        tpg_pkg::CMD_PATTERN: begin
          pattern_rom[b.addr] = b.data;
          pat_written[b.addr] = 1'b1;
        end
        tpg_pkg::CMD_BALL: begin
          ball_h = b.ball_h;
          ball_v = b.ball_v;
          ball_on = b.ball_en;
        end
        tpg_pkg::CMD_RENDER:
          pending_pixels.push_back(predict_pixel(int'(b.x), int'(b.y)));
        default: ;
      endcase
    endfunction

    function void check_pixel(logic [15:0] color, logic drawn);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel beat, expected none, actual color %h drawn %b",
                 $time, color, drawn);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (color !== want.color) begin
        $display("%0t: pixel_color expected %h actual %h", $time, want.color, color);
        errors++;
      end
      if (drawn !== want.drawn) begin
        $display("%0t: pixel_drawn expected %b actual %b", $time, want.drawn, drawn);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = 3'd0;
  logic [10:0] addr = 11'd0;
  logic [7:0]  data = 8'd0;
  logic [7:0]  ball_h_in = 8'd0;
  logic [7:0]  ball_v_in = 8'd0;
  logic        ball_enable_in = 1'b0;
  logic [7:0]  pixel_x = 8'd0;
  logic [7:0]  pixel_y = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] pixel_color;
  logic        pixel_drawn;

  pixel_tracker tracker = new();
  int send_idle_pct = 7;
  int recv_idle_pct = 61;
  int beats_sent = 0;
  int quiet_cycles = 0;

  tilemap_pixel_generator dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .addr           (addr),
    .data           (data),
    .ball_h_in      (ball_h_in),
    .ball_v_in      (ball_v_in),
    .ball_enable_in (ball_enable_in),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pixel_color    (pixel_color),
    .pixel_drawn    (pixel_drawn)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_pixel(pixel_color, pixel_drawn);
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT)
      @(posedge clk);
    $display("tilemap_pixel_generator verification failed");
    $finish;
  end

  function automatic tpg_pkg::item_t random_beat();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[54:0];
  endfunction

  // Must be entered just after a rising edge; leaves in_valid high.
  task automatic send_beat(tpg_pkg::item_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= b.cmd;
    addr <= b.addr;
    data <= b.data;
    ball_h_in <= b.ball_h;
    ball_v_in <= b.ball_v;
    ball_enable_in <= b.ball_en;
    pixel_x <= b.x;
    pixel_y <= b.y;
    do @(posedge clk); while (in_stall);
    tracker.take_command(b);
    if (b.cmd <= tpg_pkg::CMD_RENDER)
      beats_sent++;
  endtask

  task automatic write_store(tpg_pkg::cmd_t op, int where, int value);
    tpg_pkg::item_t b;
    b = random_beat();
    b.cmd = op;
    b.addr = 11'(where);
    b.data = 8'(value);
    send_beat(b);
  endtask

  task automatic set_ball(int h, int v, bit en);
    tpg_pkg::item_t b;
    b = random_beat();
    b.cmd = tpg_pkg::CMD_BALL;
    b.ball_h = 8'(h);
    b.ball_v = 8'(v);
    b.ball_en = en;
    send_beat(b);
  endtask

  // A pattern byte that has never been written is loaded first.
  task automatic render_pixel(int x, int y);
    tpg_pkg::item_t b;
    int    slot;
    slot = tracker.pattern_slot(x, y);
    if (!tracker.pat_written[slot])
      write_store(tpg_pkg::CMD_PATTERN, slot, $urandom_range(0, 255));
    b = random_beat();
    b.cmd = tpg_pkg::CMD_RENDER;
    b.x = 8'(x);
    b.y = 8'(y);
    send_beat(b);
  endtask

  initial begin
    tpg_pkg::item_t b;
    int    pick;
    int    x;
    int    y;
    int    h;
    int    v;
    int    off;
    int    code;
    int    target;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Background pixel at the origin, then the far corner cell with all-ones codes.
    write_store(tpg_pkg::CMD_PATTERN, 0, 8'h00);
    render_pixel(0, 0);
    render_pixel(7, 7);
    write_store(tpg_pkg::CMD_TILE, 11'h7FF, 8'hFF);
    write_store(tpg_pkg::CMD_COLOR, 11'h7FF, 8'hFF);
    write_store(tpg_pkg::CMD_PATTERN, 11'h7FF, 8'h01);
    render_pixel(255, 239);
    render_pixel(254, 239);
    write_store(tpg_pkg::CMD_COLOR, 11'h3FF, 8'h00);
    render_pixel(255, 239);
    // Ball window edges, both inside and just outside.
    set_ball(0, 0, 1'b1);
    render_pixel(255, 239);
    render_pixel(252, 236);
    render_pixel(251, 236);
    render_pixel(252, 235);
    set_ball(252, 16, 1'b1);
    render_pixel(0, 220);
    render_pixel(3, 223);
    set_ball(252, 16, 1'b0);
    render_pixel(0, 220);
    set_ball(255, 255, 1'b1);
    render_pixel(0, 0);
    render_pixel(100, 224);
    for (int k = 5; k < 8; k++) begin
      b = random_beat();
      b.cmd = 3'(k);
      send_beat(b);
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct <= 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct <= 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      target = beats_sent + 500;
      while (beats_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          // Load one cell's tile code, colour and one pattern row, then paint several pixels inside it.
          x = $urandom_range(0, 255);
          y = $urandom_range(0, 223);
          off = tracker.cell_index(x, y);
          code = $urandom_range(0, 255);
          write_store(tpg_pkg::CMD_TILE, off + ($urandom_range(0, 1) << 10), code);
          write_store(tpg_pkg::CMD_COLOR, off + ($urandom_range(0, 1) << 10),
                      $urandom_range(0, 255));
          write_store(tpg_pkg::CMD_PATTERN, ((code << 3) + (y & 7)) & 'h7FF,
                      $urandom_range(1, 255));
          repeat ($urandom_range(1, 6))
            render_pixel(((x + 8) & ~7) - 8 + int'($urandom_range(0, 7)),
                         (y & ~7) + int'($urandom_range(0, 7)));
        end else if (pick < 50) begin
          h = $urandom_range(0, 255);
          v = ($urandom_range(0, 99) < 80) ? $urandom_range(16, 239) : $urandom_range(0, 255);
          set_ball(h, v, $urandom_range(0, 99) < 85);
          repeat ($urandom_range(1, 4)) begin
            y = 236 - v + int'($urandom_range(0, 5)) - 1;
            x = 252 - h + int'($urandom_range(0, 5)) - 1;
            if (y < 0 || y > 255)
              y = $urandom_range(0, 223);
            if (x < 0 || x > 255)
              x = $urandom_range(0, 255);
            render_pixel(x, y);
          end
        end else if (pick < 80) begin
          y = ($urandom_range(0, 99) < 3) ? $urandom_range(224, 255) : $urandom_range(0, 223);
          render_pixel($urandom_range(0, 255), y);
        end else if (pick < 95) begin
          b = random_beat();
          b.cmd = 3'($urandom_range(0, 2));
          send_beat(b);
        end else begin
          b = random_beat();
          b.cmd = 3'($urandom_range(5, 7));
          send_beat(b);
        end
      end
    end

    in_valid <= 1'b0;
    while (tracker.pending_pixels.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_pixels.size() == 0)
      $display("tilemap_pixel_generator verification clean");
    else
      $display("tilemap_pixel_generator verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tpg_pkg.sv
rtl/tpg_tile_fetch.sv
rtl/tpg_pattern_fetch.sv
rtl/tpg_compose.sv
rtl/tilemap_pixel_generator.sv
bench/tb.sv
